### rtl/tcb_pkg.sv
package tcb_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 128;
  localparam int MAX_DRAIN = 64;
  localparam int NCELL     = MAX_ROWS * MAX_COLS;
  localparam int AW        = $clog2(NCELL);
  localparam int CW        = AW + 1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic [20:0] rune;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [7:0]  attrs;
  } cell_t;

  typedef struct packed {
    logic  cell_we;
    logic  dirty_we;
    logic  dirty_val;
    addr_t waddr;
    cell_t wcell;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    cell_t cdata;
    logic  dirty;
  } mem_rsp_t;

  localparam logic [20:0] BLANK_RUNE = 21'd32;
  localparam logic [7:0]  DEF_FG     = 8'd7;
  localparam logic [7:0]  DEF_BG     = 8'd0;
  localparam cell_t       BLANK_CELL = '{rune: BLANK_RUNE, fg: DEF_FG, bg: DEF_BG, attrs: 8'd0};

  localparam logic [4:0] REQ_PUT      = 5'd0;
  localparam logic [4:0] REQ_ADVANCE  = 5'd1;
  localparam logic [4:0] REQ_NEWLINE  = 5'd2;
  localparam logic [4:0] REQ_INDEX    = 5'd3;
  localparam logic [4:0] REQ_CR       = 5'd4;
  localparam logic [4:0] REQ_BS       = 5'd5;
  localparam logic [4:0] REQ_TAB      = 5'd6;
  localparam logic [4:0] REQ_GOTO     = 5'd7;
  localparam logic [4:0] REQ_SCROLL   = 5'd8;
  localparam logic [4:0] REQ_ERASELN  = 5'd9;
  localparam logic [4:0] REQ_ERASEDSP = 5'd10;
  localparam logic [4:0] REQ_SAVE     = 5'd11;
  localparam logic [4:0] REQ_RESTORE  = 5'd12;
  localparam logic [4:0] REQ_ATTRS    = 5'd13;
  localparam logic [4:0] REQ_SETCELL  = 5'd14;
  localparam logic [4:0] REQ_DRAIN    = 5'd15;
  localparam logic [4:0] REQ_GET      = 5'd16;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DIRTY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] ERASE_TO_END   = 2'd0;
  localparam logic [1:0] ERASE_FROM_BEG = 2'd1;
  localparam logic [1:0] ERASE_ALL      = 2'd2;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_WRAP = 2'd2;

  function automatic logic [5:0] eff_rows(input logic [5:0] r);
    logic [5:0] v;
    v = r;
    if (v == 6'd0) v = 6'd1;
    if (v > 6'(MAX_ROWS)) v = 6'(MAX_ROWS);
    return v;
  endfunction

  function automatic logic [7:0] eff_cols(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (v == 8'd0) v = 8'd1;
    if (v > 8'(MAX_COLS)) v = 8'(MAX_COLS);
    return v;
  endfunction

endpackage

### rtl/tcb_mem.sv
module tcb_mem (
  input  logic               clk,
  input  tcb_pkg::mem_req_t  req,
  output tcb_pkg::mem_rsp_t  rsp
);
  import tcb_pkg::*;

  cell_t cell_mem  [NCELL];
  logic  dirty_mem [NCELL];

  always_ff @(posedge clk) begin
    if (req.cell_we) begin
      cell_mem[req.waddr] <= req.wcell;
    end
    if (req.dirty_we) begin
      dirty_mem[req.waddr] <= req.dirty_val;
    end
    rsp <= '{cdata: cell_mem[req.raddr], dirty: dirty_mem[req.raddr]};
  end

endmodule

### rtl/terminal_cell_buffer_unit.sv
// Character-cell store of a text terminal.
// Commands enter on start/in_* and are taken when start is high and busy low.
// Every command gives one or more results on out_*, each shown for exactly
// one cycle with out_valid; out_last marks the final result of a command.
// The receiver cannot stall; results are never held back.
// Cursor, style, put, setcell, save/restore: one ack from S_ACK. Get: one read from S_GET.
// Scroll and erase walk the cell memory one cell a cycle; a scroll walks the
// whole screen. Newline, index and wrapping advance at the bottom row
// scroll by one row the same way.
// Drain scans cells in index order one a cycle until the limit is reached
// or the screen ends, then sweeps all 4096 dirty bits clear.
// The cell memory's one read port and one write port set that pace.
// After reset the block runs a clearing pass over all 4096 cells with busy high.
// The user writes configuration (cfg_we, cfg_index, cfg_data) only while
// idle; the block does not enforce it. A size write clamps both cursors.
module terminal_cell_buffer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_req_type,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_col,
  input  logic [20:0] in_rune,
  input  logic [7:0]  in_fg_color,
  input  logic [7:0]  in_bg_color,
  input  logic [7:0]  in_attr_bits,
  input  logic [1:0]  in_erase_mode,
  input  logic [6:0]  in_amount,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [11:0] out_cell_index,
  output logic [20:0] out_rune,
  output logic [7:0]  out_fg,
  output logic [7:0]  out_bg,
  output logic [7:0]  out_attrs,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic        out_last
);
  import tcb_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACK   = 3'd2;
  localparam logic [2:0] S_GET   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DCLR  = 3'd6;

  mem_req_t mreq;
  mem_rsp_t mrsp;

  tcb_mem u_mem (.clk(clk), .req(mreq), .rsp(mrsp));

  logic [2:0] state_r, state_nxt;
  logic [4:0] cur_r_r, cur_r_nxt, sav_r_r, sav_r_nxt;
  logic [6:0] cur_c_r, cur_c_nxt, sav_c_r, sav_c_nxt;
  logic [7:0] st_fg_r, st_fg_nxt, st_bg_r, st_bg_nxt, st_at_r, st_at_nxt;
  logic [7:0] sv_fg_r, sv_fg_nxt, sv_bg_r, sv_bg_nxt, sv_at_r, sv_at_nxt;
  logic       every_dirty_r, every_dirty_nxt;
  logic [5:0] rows_cfg_r, rows_cfg_nxt;
  logic [7:0] cols_cfg_r, cols_cfg_nxt;
  logic       wrap_r, wrap_nxt;
  cnt_t       i_r, i_nxt, end_r, end_nxt, copy_end_r, copy_end_nxt, shift_r, shift_nxt;
  cell_t      fill_r, fill_nxt;
  logic       p_valid_r, p_valid_nxt, p_copy_r, p_copy_nxt;
  addr_t      p_idx_r, p_idx_nxt;
  logic [6:0] n_r, n_nxt, lim_r, lim_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  addr_t      pend_idx_r, pend_idx_nxt;
  cell_t      pend_cell_r, pend_cell_nxt;
  logic       g_ok_r, g_ok_nxt;
  addr_t      g_idx_r, g_idx_nxt;
  logic       out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  addr_t      out_idx_r, out_idx_nxt;
  cell_t      out_cell_r, out_cell_nxt;

  logic [5:0] rows_e, er;
  logic [7:0] cols_e, ec;
  cnt_t       rows_w, cols_w, total, cur_lin, rs_lin, tgt_lin, shift_amt;
  logic       tgt_ok, scroll_ok, ld_bottom, drain_done;
  logic [5:0] r_inc;
  logic [4:0] ld_row;
  logic [7:0] c_inc, tab_c;

  always_comb begin
    rows_e    = eff_rows(rows_cfg_r);
    cols_e    = eff_cols(cols_cfg_r);
    rows_w    = CW'(rows_e);
    cols_w    = CW'(cols_e);
    total     = rows_w * cols_w;
    rs_lin    = CW'(cur_r_r) * cols_w;
    cur_lin   = rs_lin + CW'(cur_c_r);
    tgt_lin   = CW'(in_row) * cols_w + CW'(in_col);
    tgt_ok    = (in_row < {2'b0, rows_e}) && (in_col < cols_e);
    shift_amt = CW'(in_amount) * cols_w;
    scroll_ok = (in_amount != 7'd0) && (in_amount <= {1'b0, rows_e});
    r_inc     = {1'b0, cur_r_r} + 6'd1;
    ld_bottom = (r_inc >= rows_e);
    ld_row    = ld_bottom ? 5'(rows_e - 6'd1) : r_inc[4:0];
    c_inc     = {1'b0, cur_c_r} + 8'd1;
    tab_c     = ({1'b0, cur_c_r} + 8'd8) & ~8'd7;
    drain_done = (n_r >= lim_r) || ((i_r >= total) && !p_valid_r);
  end

  always_comb begin
    state_nxt = state_r;
    cur_r_nxt = cur_r_r;  cur_c_nxt = cur_c_r;
    sav_r_nxt = sav_r_r;  sav_c_nxt = sav_c_r;
    st_fg_nxt = st_fg_r;  st_bg_nxt = st_bg_r;  st_at_nxt = st_at_r;
    sv_fg_nxt = sv_fg_r;  sv_bg_nxt = sv_bg_r;  sv_at_nxt = sv_at_r;
    every_dirty_nxt = every_dirty_r;
    rows_cfg_nxt = rows_cfg_r;  cols_cfg_nxt = cols_cfg_r;  wrap_nxt = wrap_r;
    i_nxt = i_r;  end_nxt = end_r;  copy_end_nxt = copy_end_r;  shift_nxt = shift_r;
    fill_nxt = fill_r;
    p_valid_nxt = 1'b0;  p_copy_nxt = p_copy_r;  p_idx_nxt = p_idx_r;
    n_nxt = n_r;  lim_nxt = lim_r;
    pend_valid_nxt = pend_valid_r;  pend_idx_nxt = pend_idx_r;  pend_cell_nxt = pend_cell_r;
    g_ok_nxt = g_ok_r;  g_idx_nxt = g_idx_r;
    out_valid_nxt = 1'b0;  out_last_nxt = out_last_r;  out_kind_nxt = out_kind_r;
    out_idx_nxt = out_idx_r;  out_cell_nxt = out_cell_r;
    mreq = '0;
    er = 6'd1;
    ec = 8'd1;

    unique case (state_r)
      S_INIT: begin
        mreq.cell_we  = 1'b1;
        mreq.dirty_we = 1'b1;
        mreq.waddr    = i_r[AW-1:0];
        mreq.wcell    = BLANK_CELL;
        if (i_r == CW'(NCELL - 1)) begin
          state_nxt = S_IDLE;
        end
        i_nxt = i_r + CW'(1);
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ACK;
          fill_nxt  = '{rune: BLANK_RUNE, fg: st_fg_r, bg: st_bg_r, attrs: 8'd0};
          i_nxt        = '0;
          end_nxt      = total;
          copy_end_nxt = '0;
          shift_nxt    = '0;
          unique case (in_req_type)
            REQ_PUT: begin
              mreq.cell_we   = 1'b1;
              mreq.dirty_we  = 1'b1;
              mreq.dirty_val = 1'b1;
              mreq.waddr     = cur_lin[AW-1:0];
              mreq.wcell     = '{rune: in_rune, fg: st_fg_r, bg: st_bg_r, attrs: st_at_r};
            end
            REQ_ADVANCE: begin
              if (c_inc >= cols_e) begin
                if (wrap_r) begin
                  cur_c_nxt = '0;
                  cur_r_nxt = ld_row;
                  if (ld_bottom) begin
                    state_nxt    = S_WALK;
                    fill_nxt     = BLANK_CELL;
                    shift_nxt    = cols_w;
                    copy_end_nxt = total - cols_w;
                  end
                end else begin
                  cur_c_nxt = 7'(cols_e - 8'd1);
                end
              end else begin
                cur_c_nxt = c_inc[6:0];
              end
            end
            REQ_NEWLINE, REQ_INDEX: begin
              if (in_req_type == REQ_NEWLINE) cur_c_nxt = '0;
              cur_r_nxt = ld_row;
              if (ld_bottom) begin
                state_nxt    = S_WALK;
                fill_nxt     = BLANK_CELL;
                shift_nxt    = cols_w;
                copy_end_nxt = total - cols_w;
              end
            end
            REQ_CR: cur_c_nxt = '0;
            REQ_BS: if (cur_c_r != 7'd0) cur_c_nxt = cur_c_r - 7'd1;
            REQ_TAB: cur_c_nxt = (tab_c >= cols_e) ? 7'(cols_e - 8'd1) : tab_c[6:0];
            REQ_GOTO: begin
              cur_r_nxt = (in_row >= {2'b0, rows_e}) ? 5'(rows_e - 6'd1) : in_row[4:0];
              cur_c_nxt = (in_col >= cols_e) ? 7'(cols_e - 8'd1) : in_col[6:0];
            end
            REQ_SCROLL: begin
              if (scroll_ok) begin
                state_nxt    = S_WALK;
                fill_nxt     = BLANK_CELL;
                shift_nxt    = shift_amt;
                copy_end_nxt = total - shift_amt;
              end
            end
            REQ_ERASELN, REQ_ERASEDSP: begin
              if (in_erase_mode != 2'd3) state_nxt = S_WALK;
              if (in_req_type == REQ_ERASELN) begin
                unique case (in_erase_mode)
                  ERASE_TO_END:   begin i_nxt = cur_lin; end_nxt = rs_lin + cols_w;  end
                  ERASE_FROM_BEG: begin i_nxt = rs_lin;  end_nxt = cur_lin + CW'(1); end
                  ERASE_ALL:      begin i_nxt = rs_lin;  end_nxt = rs_lin + cols_w;  end
                  default: ;
                endcase
              end else begin
                unique case (in_erase_mode)
                  ERASE_TO_END:   begin i_nxt = cur_lin; end_nxt = total;            end
                  ERASE_FROM_BEG: begin i_nxt = '0;      end_nxt = cur_lin + CW'(1); end
                  ERASE_ALL:      begin i_nxt = '0;      end_nxt = total;            end
                  default: ;
                endcase
              end
            end
            REQ_SAVE: begin
              sav_r_nxt = cur_r_r;  sav_c_nxt = cur_c_r;
              sv_fg_nxt = st_fg_r;  sv_bg_nxt = st_bg_r;  sv_at_nxt = st_at_r;
            end
            REQ_RESTORE: begin
              cur_r_nxt = sav_r_r;  cur_c_nxt = sav_c_r;
              st_fg_nxt = sv_fg_r;  st_bg_nxt = sv_bg_r;  st_at_nxt = sv_at_r;
            end
            REQ_ATTRS: begin
              st_fg_nxt = in_fg_color;  st_bg_nxt = in_bg_color;  st_at_nxt = in_attr_bits;
            end
            REQ_SETCELL: begin
              if (tgt_ok) begin
                mreq.cell_we   = 1'b1;
                mreq.dirty_we  = 1'b1;
                mreq.dirty_val = 1'b1;
                mreq.waddr     = tgt_lin[AW-1:0];
                mreq.wcell     = '{rune: in_rune, fg: in_fg_color, bg: in_bg_color,
                                   attrs: in_attr_bits};
              end
            end
            REQ_DRAIN: begin
              state_nxt      = S_DRAIN;
              n_nxt          = '0;
              lim_nxt        = (in_amount > 7'(MAX_DRAIN)) ? 7'(MAX_DRAIN) : in_amount;
              pend_valid_nxt = 1'b0;
            end
            REQ_GET: begin
              state_nxt  = S_GET;
              mreq.raddr = tgt_lin[AW-1:0];
              g_ok_nxt   = tgt_ok;
              g_idx_nxt  = tgt_lin[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      S_ACK: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ACK;
        out_idx_nxt   = '0;
        out_cell_nxt  = '0;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_GET: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_READ;
        out_idx_nxt   = g_ok_r ? g_idx_r : '0;
        out_cell_nxt  = g_ok_r ? mrsp.cdata : '0;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (p_valid_r) begin
          mreq.cell_we   = 1'b1;
          mreq.dirty_we  = 1'b1;
          mreq.dirty_val = 1'b1;
          mreq.waddr     = p_idx_r;
          mreq.wcell     = p_copy_r ? mrsp.cdata : fill_r;
        end
        if (i_r < end_r) begin
          mreq.raddr  = AW'(i_r + shift_r);
          p_valid_nxt = 1'b1;
          p_idx_nxt   = i_r[AW-1:0];
          p_copy_nxt  = (i_r < copy_end_r);
          i_nxt       = i_r + CW'(1);
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = pend_valid_r ? KIND_DIRTY : KIND_NONE;
          out_idx_nxt   = pend_valid_r ? pend_idx_r : '0;
          out_cell_nxt  = pend_valid_r ? pend_cell_r : '0;
          every_dirty_nxt = 1'b0;
          i_nxt         = '0;
          state_nxt     = S_DCLR;
        end else begin
          if (i_r < total) begin
            mreq.raddr  = i_r[AW-1:0];
            p_valid_nxt = 1'b1;
            p_idx_nxt   = i_r[AW-1:0];
            i_nxt       = i_r + CW'(1);
          end
          if (p_valid_r && (every_dirty_r || mrsp.dirty)) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b0;
              out_kind_nxt  = KIND_DIRTY;
              out_idx_nxt   = pend_idx_r;
              out_cell_nxt  = pend_cell_r;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = p_idx_r;
            pend_cell_nxt  = mrsp.cdata;
            n_nxt          = n_r + 7'd1;
          end
        end
      end
      S_DCLR: begin
        mreq.dirty_we = 1'b1;
        mreq.waddr    = i_r[AW-1:0];
        if (i_r == CW'(NCELL - 1)) begin
          state_nxt = S_IDLE;
        end
        i_nxt = i_r + CW'(1);
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS ||
                   cfg_index == CFG_WRAP)) begin
      unique case (cfg_index)
        CFG_ROWS: rows_cfg_nxt = cfg_data[5:0];
        CFG_COLS: cols_cfg_nxt = cfg_data;
        default:  wrap_nxt     = cfg_data[0];
      endcase
      er = eff_rows(rows_cfg_nxt);
      ec = eff_cols(cols_cfg_nxt);
      if ({1'b0, cur_r_nxt} >= er) cur_r_nxt = 5'(er - 6'd1);
      if ({1'b0, cur_c_nxt} >= ec) cur_c_nxt = 7'(ec - 8'd1);
      if ({1'b0, sav_r_nxt} >= er) sav_r_nxt = 5'(er - 6'd1);
      if ({1'b0, sav_c_nxt} >= ec) sav_c_nxt = 7'(ec - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      i_r         <= '0;
      cur_r_r     <= '0;  cur_c_r <= '0;
      sav_r_r     <= '0;  sav_c_r <= '0;
      st_fg_r     <= DEF_FG;  st_bg_r <= DEF_BG;  st_at_r <= '0;
      sv_fg_r     <= '0;  sv_bg_r <= '0;  sv_at_r <= '0;
      every_dirty_r <= 1'b1;
      rows_cfg_r  <= 6'd24;
      cols_cfg_r  <= 8'd80;
      wrap_r      <= 1'b1;
      p_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      cur_r_r     <= cur_r_nxt;  cur_c_r <= cur_c_nxt;
      sav_r_r     <= sav_r_nxt;  sav_c_r <= sav_c_nxt;
      st_fg_r     <= st_fg_nxt;  st_bg_r <= st_bg_nxt;  st_at_r <= st_at_nxt;
      sv_fg_r     <= sv_fg_nxt;  sv_bg_r <= sv_bg_nxt;  sv_at_r <= sv_at_nxt;
      every_dirty_r <= every_dirty_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      wrap_r      <= wrap_nxt;
      p_valid_r   <= p_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    copy_end_r  <= copy_end_nxt;
    shift_r     <= shift_nxt;
    fill_r      <= fill_nxt;
    p_copy_r    <= p_copy_nxt;
    p_idx_r     <= p_idx_nxt;
    n_r         <= n_nxt;
    lim_r       <= lim_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_cell_r <= pend_cell_nxt;
    g_ok_r      <= g_ok_nxt;
    g_idx_r     <= g_idx_nxt;
    out_last_r  <= out_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_cell_r  <= out_cell_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_cell_index = out_idx_r;
  assign out_rune       = out_cell_r.rune;
  assign out_fg         = out_cell_r.fg;
  assign out_bg         = out_cell_r.bg;
  assign out_attrs      = out_cell_r.attrs;
  assign out_cursor_row = cur_r_r;
  assign out_cursor_col = cur_c_r;
  assign out_last       = out_last_r;

endmodule
